// ----- design/frp_pkg.sv -----
`default_nettype none
package frp_pkg;

  localparam int SAMPLE_W = 16;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ORDER_0 = 2'd0,
    ORDER_1 = 2'd1,
    ORDER_2 = 2'd2,
    ORDER_3 = 2'd3
  } order_t;

  typedef struct packed {
    logic                       op;
    logic [1:0]                 order;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_channel;
    logic                       out_last;
  } out_item_t;

  // one queued sample beat, already classified by the front
  typedef struct packed {
    logic                       clear;
    logic                       warm;
    logic [1:0]                 order;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ----- design/fixed_predictor_reconstruct_unit.sv -----
// channel | direction | handshake          | beat payload
// in_     | input     | in_valid/in_stall  | in_item_t: op, order, channel, value, last
// out_    | output    | out_valid/out_stall| out_item_t: sample, out_channel, out_last
//
// one beat per cycle sustained while out_stall stays low; a sample beat taken is
// written into the queue and popped into the output register, which raises
// out_valid; start beats give no output beat.
// the predictor add and history shift happen together on each pop in the back end.
// synchronous active-low reset empties the queue and zeroes order, channel
// and history; no clearing pass is needed.
// in_stall rises only when the queue is full, i.e. out_stall has held it up.
`default_nettype none
module fixed_predictor_reconstruct_unit import frp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  queue_status_t q_status;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic          push;
  logic          pop;

  frp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .queue_full (q_status.full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  frp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .status   (q_status),
    .head_cmd (head_cmd)
  );

  frp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (q_status.empty),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

// ----- design/frp_queue.sv -----
`default_nettype none
module frp_queue import frp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cmd_t          push_cmd,
  input  wire logic          pop,
  output queue_status_t      status,
  output cmd_t               head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head_cmd     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- design/frp_front.sv -----
`default_nettype none
module frp_front import frp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     queue_full,
  output logic          push,
  output cmd_t          push_cmd
);

  logic [1:0] active_order_r, active_order_nxt;
  logic [1:0] warmup_left_r, warmup_left_nxt;
  logic       active_channel_r, active_channel_nxt;
  logic       clear_pend_r, clear_pend_nxt;
  logic       accept;
  logic       is_sample;

  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign is_sample = (in_item.op == OP_SAMPLE);
  assign push      = accept && is_sample;

  always_comb begin
    push_cmd.clear   = clear_pend_r;
    push_cmd.warm    = (warmup_left_r != 2'd0);
    push_cmd.order   = active_order_r;
    push_cmd.channel = active_channel_r;
    push_cmd.value   = in_item.value;
    push_cmd.last    = in_item.last;
  end

  always_comb begin
    active_order_nxt   = active_order_r;
    warmup_left_nxt    = warmup_left_r;
    active_channel_nxt = active_channel_r;
    clear_pend_nxt     = clear_pend_r;
    if (accept) begin
      if (!is_sample) begin
        active_order_nxt   = in_item.order;
        warmup_left_nxt    = in_item.order;
        active_channel_nxt = in_item.channel;
        clear_pend_nxt     = 1'b1;
      end else begin
        // history wipe rides along with the first sample after a start
        clear_pend_nxt = 1'b0;
        if (warmup_left_r != 2'd0) begin
          warmup_left_nxt = warmup_left_r - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_order_r   <= ORDER_0;
      warmup_left_r    <= 2'd0;
      active_channel_r <= 1'b0;
      clear_pend_r     <= 1'b0;
    end else begin
      active_order_r   <= active_order_nxt;
      warmup_left_r    <= warmup_left_nxt;
      active_channel_r <= active_channel_nxt;
      clear_pend_r     <= clear_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/frp_back.sv -----
`default_nettype none
module frp_back import frp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  queue_empty,
  input  wire cmd_t  head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_item
);

  logic [SAMPLE_W-1:0] hist_r [3];
  logic [SAMPLE_W-1:0] x1, x2, x3;
  logic [SAMPLE_W-1:0] pred;
  logic [SAMPLE_W-1:0] result;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r;

  assign pop       = !queue_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign x1 = head_cmd.clear ? '0 : hist_r[0];
  assign x2 = head_cmd.clear ? '0 : hist_r[1];
  assign x3 = head_cmd.clear ? '0 : hist_r[2];

  always_comb begin
    case (order_t'(head_cmd.order))
      ORDER_1: pred = x1;
      ORDER_2: pred = (x1 << 1) - x2;
      ORDER_3: pred = (x1 << 1) + x1 - (x2 << 1) - x2 + x3;
      default: pred = '0;
    endcase
  end

  assign result = head_cmd.warm ? head_cmd.value : pred + head_cmd.value;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hist_r[0]   <= '0;
      hist_r[1]   <= '0;
      hist_r[2]   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        hist_r[0] <= result;
        hist_r[1] <= x1;
        hist_r[2] <= x2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r.sample      <= result;
      out_item_r.out_channel <= head_cmd.channel;
      out_item_r.out_last    <= head_cmd.last;
    end
  end

endmodule
`default_nettype wire

// ----- design/frp_checker.sv -----
`default_nettype none
module frp_checker import frp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output beat changed while stalled");

  // a fresh output beat traces back to an accepted sample beat
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_item.op == OP_SAMPLE, 2))
    else $error("output beat without a sample beat");

  // input backpressure only follows a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled while output was free");

endmodule

bind fixed_predictor_reconstruct_unit frp_checker u_frp_checker (.*);
`default_nettype wire
